// File: rtl/qgfm_pkg.sv
// ----------------------------------------------------------------------------
// qgfm_pkg: shared types and constants for the Q-format gain block
// Beat payload structs, register indexes and numeric limits.
// ----------------------------------------------------------------------------
`default_nettype none

package qgfm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned ProdW   = 64;
  localparam int unsigned FracW   = 5;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_VALUE    = 2'd0,
    CFG_FRAC_BITS     = 2'd1,
    CFG_MIX_ENABLE    = 2'd2,
    CFG_NARROW_OUTPUT = 2'd3
  } cfg_index_t;

  localparam logic signed [SampleW-1:0] GainReset = 32'sd32768;
  localparam logic [FracW-1:0]          FracReset = 5'd15;

  localparam logic signed [SampleW-1:0] Sat32Max = 32'sh7FFF_FFFF;
  localparam logic signed [SampleW-1:0] Sat32Min = 32'sh8000_0000;
  localparam logic signed [SampleW-1:0] Sat16Max = 32'sd32767;
  localparam logic signed [SampleW-1:0] Sat16Min = -32'sd32768;

  typedef struct packed {
    logic signed [SampleW-1:0] in_sample;
    logic signed [SampleW-1:0] prior_out;
    logic                      in_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic                      out_last;
  } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/qgfm_stream_if.sv
// ----------------------------------------------------------------------------
// qgfm_stream_if: valid/ready stream channel
// Carries one payload beat per handshake; source drives valid and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface qgfm_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: rtl/qformat_gain_fill_mix_top.sv
// ----------------------------------------------------------------------------
// qformat_gain_fill_mix_top: Q-format gain with saturating fill or mix
// Applies a signed Q-format gain to each sample, rounds, shifts and
// saturates, then fills or adds with saturation into the prior output;
// narrow output instead clamps to 16 bits and does not mix.
// Channels: in_ch takes beats of in_sample, prior_out and in_last; out_ch
// gives beats of out_sample and out_last. Both use valid/ready; a beat
// moves when both are high. cfg_we/cfg_index/cfg_wdata write the gain,
// fractional bits, mix enable and narrow output registers. The user must
// write them only while idle; the block itself does not enforce this.
// Throughput: one beat per cycle while out_ch.ready is high; four register stages
// (multiply, round add, shift and clamp, shortcut select and mix add).
// Reset: synchronous, rst_n low empties all stages and loads the register
// defaults (gain 32768, 15 fractional bits, fill, full width).
// Stall: while out_ch.ready is low the result holds; stages behind it
// keep filling until full, then in_ch.ready drops. Nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module qformat_gain_fill_mix_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  qgfm_stream_if.sink                        in_ch,
  qgfm_stream_if.source                      out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [qgfm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [qgfm_pkg::SampleW-1:0]  cfg_wdata
);

  import qgfm_pkg::*;

  logic signed [SampleW-1:0] gain_r;
  logic [FracW-1:0]          frac_r;
  logic                      mix_r;
  logic                      narrow_r;

  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic adv1, adv2, adv3, adv4;

  logic signed [SampleW-1:0] s1_x_r, s1_p_r, s2_x_r, s2_p_r, s3_x_r, s3_p_r;
  logic                      s1_l_r, s2_l_r, s3_l_r;
  logic signed [ProdW-1:0]   prod_nxt, prod_r;
  logic signed [ProdW-1:0]   rnd_term;
  logic signed [ProdW-1:0]   rnd_nxt, rnd_r;
  logic signed [ProdW-1:0]   shifted;
  logic signed [SampleW-1:0] g32_nxt, g32_r;
  out_beat_t                 out_nxt, out_r;

  logic [SampleW:0]          unity33;
  logic [SampleW:0]          gain33;
  logic                      unity_hit;
  logic                      neg_hit;
  logic signed [SampleW:0]   add_x, sub_x, neg_x, add_g;

  function automatic logic signed [SampleW-1:0] sat33(input logic signed [SampleW:0] v);
    logic signed [SampleW-1:0] r;
    if (v[SampleW] == v[SampleW-1]) begin
      r = v[SampleW-1:0];
    end else if (v[SampleW]) begin
      r = Sat32Min;
    end else begin
      r = Sat32Max;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GainReset;
      frac_r   <= FracReset;
      mix_r    <= 1'b0;
      narrow_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_GAIN_VALUE:    gain_r   <= cfg_wdata;
        CFG_FRAC_BITS:     frac_r   <= cfg_wdata[FracW-1:0];
        CFG_MIX_ENABLE:    mix_r    <= cfg_wdata[0];
        CFG_NARROW_OUTPUT: narrow_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage advance chain
  assign adv4 = !out_v_r || out_ch.ready;
  assign adv3 = !s3_v_r || adv4;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r  <= in_ch.valid;
      if (adv2) s2_v_r  <= s1_v_r;
      if (adv3) s3_v_r  <= s2_v_r;
      if (adv4) out_v_r <= s3_v_r;
    end
  end

  // stage 1: multiply
  assign prod_nxt = in_ch.data.in_sample * gain_r;

  // stage 2: add rounding term
  always_comb begin
    if (frac_r == '0) begin
      rnd_term = '0;
    end else begin
      rnd_term = ProdW'(1) << (frac_r - FracW'(1));
    end
    rnd_nxt = prod_r + rnd_term;
  end

  // stage 3: shift and clamp to 32 bits
  always_comb begin
    shifted = rnd_r >>> frac_r;
    if (&shifted[ProdW-1:SampleW-1] || ~|shifted[ProdW-1:SampleW-1]) begin
      g32_nxt = shifted[SampleW-1:0];
    end else if (shifted[ProdW-1]) begin
      g32_nxt = Sat32Min;
    end else begin
      g32_nxt = Sat32Max;
    end
  end

  // stage 4: narrow clamp, shortcut select and mix
  always_comb begin
    unity33   = (SampleW+1)'(1) << frac_r;
    gain33    = {gain_r[SampleW-1], gain_r};
    unity_hit = (gain33 == unity33) || (gain33 == unity33 - (SampleW+1)'(1));
    neg_hit   = (gain33 == (~unity33 + (SampleW+1)'(1)));
    add_x     = {s3_p_r[SampleW-1], s3_p_r} + {s3_x_r[SampleW-1], s3_x_r};
    sub_x     = {s3_p_r[SampleW-1], s3_p_r} - {s3_x_r[SampleW-1], s3_x_r};
    neg_x     = -{s3_x_r[SampleW-1], s3_x_r};
    add_g     = {s3_p_r[SampleW-1], s3_p_r} + {g32_r[SampleW-1], g32_r};
    out_nxt.out_last = s3_l_r;
    if (narrow_r) begin
      if (g32_r > Sat16Max) begin
        out_nxt.out_sample = Sat16Max;
      end else if (g32_r < Sat16Min) begin
        out_nxt.out_sample = Sat16Min;
      end else begin
        out_nxt.out_sample = g32_r;
      end
    end else if (unity_hit) begin
      out_nxt.out_sample = mix_r ? sat33(add_x) : s3_x_r;
    end else if (neg_hit) begin
      out_nxt.out_sample = mix_r ? sat33(sub_x) : sat33(neg_x);
    end else begin
      out_nxt.out_sample = mix_r ? sat33(add_g) : g32_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      prod_r <= prod_nxt;
      s1_x_r <= in_ch.data.in_sample;
      s1_p_r <= in_ch.data.prior_out;
      s1_l_r <= in_ch.data.in_last;
    end
    if (adv2) begin
      rnd_r  <= rnd_nxt;
      s2_x_r <= s1_x_r;
      s2_p_r <= s1_p_r;
      s2_l_r <= s1_l_r;
    end
    if (adv3) begin
      g32_r  <= g32_nxt;
      s3_x_r <= s2_x_r;
      s3_p_r <= s2_p_r;
      s3_l_r <= s2_l_r;
    end
    if (adv4) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

`default_nettype wire

// File: tb/qformat_gain_fill_mix_top_tb.sv
// ----------------------------------------------------------------------------
// qformat_gain_fill_mix_top_tb: Q-format gain, fill and mix regression
// A table of corner samples with typed or predicted results runs first.
// Randomized phases follow, each with new gain, fractional bits, mix and
// narrow settings. Both sides idle at random; the sink holds off twice
// for long stretches. Beats are checked against typed or model results.
// ----------------------------------------------------------------------------
module qformat_gain_fill_mix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qgfm_pkg::*;

  typedef struct {
    logic [31:0] gain;
    logic [4:0]  frac;
    bit          mix;
    bit          narrow;
    logic [31:0] sample;
    logic [31:0] prior;
    bit          last;
    bit          typed;
    logic [31:0] result;
  } stim_row_t;

  localparam int DirRows   = 25;
  localparam int Phases    = 25;
  localparam int PhaseLen  = 50;
  localparam int HoldOff   = 300;
  localparam int DrainWait = 8;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [31:0]      cfg_wdata;

  qgfm_stream_if #(.payload_t(in_beat_t))  in_ch  ();
  qgfm_stream_if #(.payload_t(out_beat_t)) out_ch ();

  qformat_gain_fill_mix_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  int          gain_q   = 32768;
  logic [4:0]  frac_q   = 5'd15;
  bit          mix_q    = 1'b0;
  bit          narrow_q = 1'b0;

  out_beat_t   awaited_out[$];
  int          mismatch_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_off_req = 1'b0;
  int          hold_off_left = 0;

  logic [31:0] corner_vals [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                   32'hFFFF_FFFF, 32'h0000_7FFF, 32'hFFFF_8000};

  stim_row_t dir_tab [DirRows] = '{
    // gain          frac   mix   nar   sample         prior          last  typed result
    '{32'h0000_8000, 5'd15, 1'b0, 1'b0, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1, 32'h1234_5678},
    '{32'h0000_8000, 5'd15, 1'b0, 1'b0, 32'h8000_0000, 32'hDEAD_BEEF, 1'b0, 1'b1, 32'h8000_0000},
    '{32'h0000_8000, 5'd15, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h0000_7FFF, 5'd15, 1'b0, 1'b0, 32'hFFFF_FFFB, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFB},
    '{32'hFFFF_8000, 5'd15, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'hFFFF_8000, 5'd15, 1'b0, 1'b0, 32'h0000_0064, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FF9C},
    '{32'h0000_8000, 5'd15, 1'b1, 1'b0, 32'h0000_0100, 32'h7FFF_FFF0, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h0000_8000, 5'd15, 1'b1, 1'b0, 32'h0000_0005, 32'h0000_0007, 1'b0, 1'b1, 32'h0000_000C},
    '{32'hFFFF_8000, 5'd15, 1'b1, 1'b0, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{32'hFFFF_8000, 5'd15, 1'b1, 1'b0, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h0000_4000, 5'd15, 1'b0, 1'b0, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_4000, 5'd15, 1'b0, 1'b0, 32'hFFFF_FFFD, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_4000, 5'd15, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h7FFF_FFFF, 5'd0,  1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 5'd0,  1'b0, 1'b0, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 5'd0,  1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, 32'h0000_0003, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0002},
    '{32'h8000_0000, 5'd31, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 5'd31, 1'b0, 1'b0, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFF9},
    '{32'h7FFF_FFFF, 5'd31, 1'b1, 1'b0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h4000_0000, 5'd31, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{32'h0000_8000, 5'd15, 1'b1, 1'b1, 32'h0001_0000, 32'h0000_007B, 1'b0, 1'b1, 32'h0000_7FFF},
    '{32'h0000_8000, 5'd15, 1'b1, 1'b1, 32'hFFFF_0000, 32'h0000_007B, 1'b1, 1'b1, 32'hFFFF_8000},
    '{32'h7FFF_FFFF, 5'd0,  1'b0, 1'b1, 32'h0000_04D2, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_7FFF}
  };

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint scale_by_gain(longint x);
    longint p;
    p = x * longint'(gain_q);
    if (frac_q != 5'd0) p += longint'(1) << (frac_q - 5'd1);
    p = p >>> frac_q;
    return clamp_to(p, longint'(Sat32Min), longint'(Sat32Max));
  endfunction

  function automatic out_beat_t predict_gain_mix(in_beat_t beat);
    longint    x;
    longint    prior;
    longint    unity;
    longint    r;
    out_beat_t o;
    x     = longint'($signed(beat.in_sample));
    prior = longint'($signed(beat.prior_out));
    unity = longint'(1) << frac_q;
    if (narrow_q) begin
      r = clamp_to(scale_by_gain(x), longint'(Sat16Min), longint'(Sat16Max));
    end else if (longint'(gain_q) == unity || longint'(gain_q) == unity - 1) begin
      r = mix_q ? clamp_to(prior + x, longint'(Sat32Min), longint'(Sat32Max)) : x;
    end else if (longint'(gain_q) == -unity) begin
      r = mix_q ? clamp_to(prior - x, longint'(Sat32Min), longint'(Sat32Max))
                : clamp_to(-x, longint'(Sat32Min), longint'(Sat32Max));
    end else begin
      r = scale_by_gain(x);
      if (mix_q) r = clamp_to(prior + r, longint'(Sat32Min), longint'(Sat32Max));
    end
    o.out_sample = r[31:0];
    o.out_last   = beat.in_last;
    return o;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (mismatch_count < 10)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
    mismatch_count++;
  endtask

  // hold valid across back-to-back beats; drop it only when idling
  task automatic send_beat(in_beat_t beat, bit typed, out_beat_t typed_out);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= beat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_out.push_back(typed ? typed_out : predict_gain_mix(beat));
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic program_setting(logic [31:0] gain, logic [4:0] frac, bit mix, bit narrow);
    cfg_index_t  idx;
    logic [31:0] word;
    bit          needed;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_index_t'(k);
      case (idx)
        CFG_GAIN_VALUE: begin
          needed = (gain != gain_q);
          word   = gain;
        end
        CFG_FRAC_BITS: begin
          needed = (frac != frac_q);
          word   = ($urandom() & ~32'h1F) | 32'(frac);
        end
        CFG_MIX_ENABLE: begin
          needed = (mix != mix_q);
          word   = ($urandom() & ~32'h1) | 32'(mix);
        end
        default: begin
          needed = (narrow != narrow_q);
          word   = ($urandom() & ~32'h1) | 32'(narrow);
        end
      endcase
      if (needed) begin
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(posedge clk);
      end
    end
    cfg_we   <= 1'b0;
    gain_q   = gain;
    frac_q   = frac;
    mix_q    = mix;
    narrow_q = narrow;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : rx_side
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req  = 1'b0;
        hold_off_left = HoldOff;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    out_beat_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_out.size() == 0) begin
        note_mismatch("unawaited beat, out_sample", 'x, out_ch.data.out_sample);
      end else begin
        w = awaited_out.pop_front();
        if (out_ch.data.out_sample !== w.out_sample)
          note_mismatch("out_sample", w.out_sample, out_ch.data.out_sample);
        if (out_ch.data.out_last !== w.out_last)
          note_mismatch("out_last", 32'(w.out_last), 32'(out_ch.data.out_last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_beat_t    beat;
    out_beat_t   typed_out;
    stim_row_t   row;
    logic [31:0] gain;
    logic [31:0] raw;
    logic [4:0]  frac;
    longint      unity;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_GAIN_VALUE;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 12;
    rx_idle_pct = 57;
    for (int i = 0; i < DirRows; i++) begin
      row = dir_tab[i];
      if (row.gain != gain_q || row.frac != frac_q || row.mix != mix_q ||
          row.narrow != narrow_q) begin
        drain_pipe();
        program_setting(row.gain, row.frac, row.mix, row.narrow);
      end
      beat.in_sample       = row.sample;
      beat.prior_out       = row.prior;
      beat.in_last         = row.last;
      typed_out.out_sample = row.result;
      typed_out.out_last   = row.last;
      send_beat(beat, row.typed, typed_out);
    end

    for (int p = 0; p < Phases; p++) begin
      tx_idle_pct = (p < 9) ? 12 : (p < 17) ? 57 : 0;
      rx_idle_pct = (p < 9) ? 57 : (p < 17) ? 12 : 0;
      case (p)
        0, 9, 17:  frac = 5'd0;
        1, 10, 18: frac = 5'd31;
        default:   frac = 5'($urandom_range(31));
      endcase
      unity = longint'(1) << frac;
      case ($urandom_range(8))
        0:       gain = unity[31:0];
        1:       gain = unity[31:0] - 32'd1;
        2:       gain = -unity[31:0];
        3:       gain = $urandom();
        4:       gain = unity[31:0] - 32'd4 + 32'($urandom_range(8));
        5:       gain = 32'h7FFF_FFFF;
        6:       gain = 32'h8000_0000;
        7:       gain = 32'(int'($urandom()) >>> ((frac > 5'd28) ? 0 : 29 - frac));
        default: gain = 32'h0000_0000;
      endcase
      drain_pipe();
      program_setting(gain, frac, 1'($urandom_range(1)), ($urandom_range(3) == 0));
      if (p == 5 || p == 21) hold_off_req = 1'b1;
      for (int n = 0; n < PhaseLen; n++) begin
        raw = $urandom();
        case ($urandom_range(7))
          0, 1:    beat.in_sample = raw;
          2, 3:    beat.in_sample = {{16{raw[15]}}, raw[15:0]};
          4:       beat.in_sample = corner_vals[$urandom_range(5)];
          default: beat.in_sample = 32'($urandom_range(2000)) - 32'd1000;
        endcase
        case ($urandom_range(3))
          0, 1:    beat.prior_out = $urandom();
          2:       beat.prior_out = corner_vals[$urandom_range(5)];
          default: beat.prior_out = 32'($urandom_range(2000)) - 32'd1000;
        endcase
        beat.in_last = ($urandom_range(7) == 0);
        send_beat(beat, 1'b0, typed_out);
      end
    end

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/qgfm_pkg.sv
rtl/qgfm_stream_if.sv
rtl/qformat_gain_fill_mix_top.sv
tb/qformat_gain_fill_mix_top_tb.sv
